// File: hdl/cdc_ethernet_descriptor_finder_assert.svh
// Assertion macros for the descriptor finder checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef CDC_ETHERNET_DESCRIPTOR_FINDER_ASSERT_SVH
`define CDC_ETHERNET_DESCRIPTOR_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/cdf_pkg.sv
// Shared types and constants for the CDC Ethernet descriptor finder.
// No dependencies; imported by every module of the block.
`default_nettype none
package cdf_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	localparam int SEG_W      = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr above the byte lanes
	localparam logic REG_DEFAULT_SEGMENT = 1'b0;

	localparam logic [7:0]       KIND_CS_INTERFACE = 8'h24;
	localparam logic [7:0]       SUBTYPE_ETHERNET  = 8'h0F;
	localparam logic [7:0]       MIN_FUNC_LEN      = 8'd13;
	localparam logic [7:0]       MIN_RECORD_LEN    = 8'd2;
	localparam logic [7:0]       MIN_BLOCK_LEN     = 8'd9;
	localparam logic [SEG_W-1:0] RESET_SEGMENT     = 16'd1514;

	// byte positions inside a record
	localparam logic [3:0] POS_KIND    = 4'd1;
	localparam logic [3:0] POS_SUBTYPE = 4'd2;
	localparam logic [3:0] POS_MAC_IDX = 4'd3;
	localparam logic [3:0] POS_SEG_LO  = 4'd8;
	localparam logic [3:0] POS_SEG_HI  = 4'd9;

	typedef enum logic [1:0] {
		ST_SCANNING,
		ST_FOUND,
		ST_STOPPED
	} scan_state_t;

	typedef struct packed {
		logic             found;
		logic [7:0]       mac_index;
		logic [SEG_W-1:0] segment;
	} scan_result_t;

endpackage
`default_nettype wire

// File: hdl/cdf_apb_regs.sv
// APB register file: holds the default segment size.
// Depends on cdf_pkg.
`default_nettype none
module cdf_apb_regs import cdf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [SEG_W-1:0]      default_segment
);

	logic             reg_hit;
	logic [SEG_W-1:0] default_segment_q;

	assign reg_hit = (paddr[APB_ADDR_W-1] == REG_DEFAULT_SEGMENT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_segment_q <= RESET_SEGMENT;
		end else if (psel && penable && pwrite && reg_hit) begin
			default_segment_q <= pwdata[SEG_W-1:0];
		end
	end

	assign prdata          = reg_hit ? APB_DATA_W'(default_segment_q) : '0;
	assign default_segment = default_segment_q;

endmodule
`default_nettype wire

// File: hdl/cdf_scan_core.sv
// Record walker: stream state, per-byte next-state logic and the result
// computed on the last byte of a block. Depends on cdf_pkg.
`default_nettype none
module cdf_scan_core import cdf_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [7:0]       data,
	input  wire logic             last,
	input  wire logic [SEG_W-1:0] default_segment,
	output scan_result_t          result
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [7:0]             length_q, length_n;
	logic [7:0]             kind_q, kind_n;
	logic                   pending_q, pending_n;
	logic [7:0]             index_q, index_n;
	logic [SEG_W-1:0]       segment_q, segment_n;
	scan_state_t            status_q, status_n;

	logic [OFFSET_BITS-1:0] rel;
	logic [OFFSET_BITS:0]   rec_end;
	logic                   match_now;
	logic                   hit;

	assign rel       = offset_q - start_q;
	assign rec_end   = {1'b0, start_q} + (OFFSET_BITS+1)'(length_q);
	assign match_now = (rel == OFFSET_BITS'(POS_SUBTYPE)) && (kind_q == KIND_CS_INTERFACE)
		&& (length_q >= MIN_FUNC_LEN) && (data == SUBTYPE_ETHERNET);

	// next state
	always_comb begin
		offset_n  = offset_q;
		start_n   = start_q;
		length_n  = length_q;
		kind_n    = kind_q;
		pending_n = pending_q;
		index_n   = index_q;
		segment_n = segment_q;
		status_n  = status_q;
		if (offset_q == OFF_MAX) begin
			// stop at the offset limit, keep an earlier match
			if (status_q == ST_SCANNING) begin
				status_n = ST_STOPPED;
			end
		end else begin
			offset_n = offset_q + 1'b1;
			if (status_q == ST_SCANNING) begin
				if (offset_q == '0) begin
					start_n = OFFSET_BITS'(data);
					if (data == '0) begin
						status_n = ST_STOPPED;
					end
				end else if (offset_q >= start_q) begin
					if (rel == '0) begin
						length_n = data;
						if (data < MIN_RECORD_LEN) begin
							status_n = ST_STOPPED;
						end
					end else begin
						if (rel == OFFSET_BITS'(POS_KIND)) begin
							kind_n = data;
						end
						pending_n = pending_q || match_now;
						if (pending_n) begin
							if (rel == OFFSET_BITS'(POS_MAC_IDX)) begin
								index_n = data;
							end else if (rel == OFFSET_BITS'(POS_SEG_LO)) begin
								segment_n = {segment_q[SEG_W-1:8], data};
							end else if (rel == OFFSET_BITS'(POS_SEG_HI)) begin
								segment_n = {data, segment_q[7:0]};
							end
						end
						if (rel == OFFSET_BITS'(length_q - 8'd1)) begin
							if (pending_n) begin
								status_n = ST_FOUND;
							end else if (rec_end >= {1'b0, OFF_MAX}) begin
								status_n = ST_STOPPED;
							end else begin
								start_n = rec_end[OFFSET_BITS-1:0];
							end
						end
					end
				end
			end
		end
	end

	// result for the block that ends with this byte
	always_comb begin
		hit              = (status_n == ST_FOUND) && (offset_n >= OFFSET_BITS'(MIN_BLOCK_LEN));
		result.found     = hit;
		result.mac_index = hit ? index_n : '0;
		result.segment   = (hit && (segment_n != '0)) ? segment_n : default_segment;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			start_q   <= '0;
			length_q  <= '0;
			kind_q    <= '0;
			pending_q <= 1'b0;
			index_q   <= '0;
			segment_q <= '0;
			status_q  <= ST_SCANNING;
		end else if (fire) begin
			if (last) begin
				// start over for the next block
				offset_q  <= '0;
				start_q   <= '0;
				length_q  <= '0;
				kind_q    <= '0;
				pending_q <= 1'b0;
				index_q   <= '0;
				segment_q <= '0;
				status_q  <= ST_SCANNING;
			end else begin
				offset_q  <= offset_n;
				start_q   <= start_n;
				length_q  <= length_n;
				kind_q    <= kind_n;
				pending_q <= pending_n;
				index_q   <= index_n;
				segment_q <= segment_n;
				status_q  <= status_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/cdc_ethernet_descriptor_finder.sv
// CDC Ethernet functional descriptor finder, top level.
// Throughput: one byte per cycle, except while a last byte waits on a stalled output.
// A last byte goes from the byte input register to the result register and waits in the first while the output stalls.
// Other bytes keep flowing while a result waits; only a last byte holds until it leaves.
// Reset (arst_n low) clears the scan state and the valids and sets the
// default segment register to 1514. Depends on cdf_pkg, cdf_apb_regs, cdf_scan_core.
`default_nettype none
module cdc_ethernet_descriptor_finder import cdf_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            config_byte,
	input  wire logic                  last_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic      [7:0]            mac_string_index,
	output logic      [SEG_W-1:0]      segment_size,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             out_free;
	logic             advance;
	logic             in_take;
	logic [SEG_W-1:0] default_segment;
	scan_result_t     result;
	logic             out_valid_q;
	scan_result_t     result_q;

	cdf_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.default_segment (default_segment)
	);

	// a byte that ends no block never waits on the output side
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= config_byte;
			last_s1 <= last_byte;
		end
	end

	cdf_scan_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (advance),
		.data            (byte_s1),
		.last            (last_s1),
		.default_segment (default_segment),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = result_q.found;
	assign mac_string_index = result_q.mac_index;
	assign segment_size     = result_q.segment;

endmodule
`default_nettype wire

// File: hdl/cdf_checker.sv
// Port-level checks for the descriptor finder, bound to the top level.
// Depends on cdf_pkg and the assertion macro header.
`default_nettype none
`include "cdc_ethernet_descriptor_finder_assert.svh"
module cdf_checker import cdf_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             last_byte,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             found,
	input wire logic [7:0]       mac_string_index,
	input wire logic [SEG_W-1:0] segment_size,
	input wire logic             pready
);

	logic             last_take;
	logic             out_wait;
	logic [SEG_W+8:0] out_word;

	assign last_take = in_valid && !in_stall && last_byte;
	assign out_wait  = out_valid && out_stall;
	assign out_word  = {found, mac_string_index, segment_size};

	`CDF_ASSERT_NOW(a_miss_idx, out_valid && !found, mac_string_index == '0, "index on miss")
	`CDF_ASSERT_NOW(a_result_lat, $rose(out_valid), $past(last_take, 2), "no last beat")
	`CDF_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
	`CDF_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled beat changed")

endmodule

bind cdc_ethernet_descriptor_finder cdf_checker u_cdf_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
// Testbench for cdc_ethernet_descriptor_finder: byte streams in, one report per block out.
// Predicts every report from its own scan model and checks it field by field.
// Depends on cdf_pkg and the cdc_ethernet_descriptor_finder RTL.
`timescale 1ns / 100ps

module testbench;
	import cdf_pkg::*;

	localparam int OFF_LIMIT   = (1 << OFFSET_BITS_DEF) - 1;
	localparam int RANDOM_BYTES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            config_byte = 8'h00;
	logic                  last_byte = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  found;
	logic [7:0]            mac_string_index;
	logic [SEG_W-1:0]      segment_size;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cdc_ethernet_descriptor_finder u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.config_byte      (config_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.mac_string_index (mac_string_index),
		.segment_size     (segment_size),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scan model state
	logic [15:0]      scan_offset;
	logic [15:0]      rec_start;
	logic [7:0]       rec_len;
	logic [7:0]       rec_kind;
	bit               eth_pending;
	logic [7:0]       eth_index;
	logic [SEG_W-1:0] eth_segment;
	scan_state_t      scan_state;
	logic [SEG_W-1:0] default_seg = RESET_SEGMENT;

	scan_result_t expected_reports[$];
	int           bad_reports = 0;
	logic [7:0]   blk[$];
	int           burst_left = 0;
	int           random_sent = 0;

	function automatic void restart_scan();
		scan_offset = '0;
		rec_start   = '0;
		rec_len     = '0;
		rec_kind    = '0;
		eth_pending = 1'b0;
		eth_index   = '0;
		eth_segment = '0;
		scan_state  = ST_SCANNING;
	endfunction

	function automatic void scan_descriptor_byte(input logic [7:0] b);
		int unsigned o;
		int unsigned rel;
		int unsigned nxt;
		o = scan_offset;
		if (o >= OFF_LIMIT) begin
			if (scan_state == ST_SCANNING)
				scan_state = ST_STOPPED;
			return;
		end
		scan_offset = o + 1;
		if (scan_state != ST_SCANNING)
			return;
		if (o == 0) begin
			rec_start = {8'h00, b};
			if (b == 8'h00)
				scan_state = ST_STOPPED;
			return;
		end
		if (o < rec_start)
			return;
		rel = o - rec_start;
		if (rel == 0) begin
			rec_len = b;
			if (b < MIN_RECORD_LEN)
				scan_state = ST_STOPPED;
			return;
		end
		if (rel == POS_KIND)
			rec_kind = b;
		if (rel == POS_SUBTYPE && rec_kind == KIND_CS_INTERFACE &&
				rec_len >= MIN_FUNC_LEN && b == SUBTYPE_ETHERNET)
			eth_pending = 1'b1;
		if (eth_pending) begin
			if (rel == POS_MAC_IDX)
				eth_index = b;
			else if (rel == POS_SEG_LO)
				eth_segment[7:0] = b;
			else if (rel == POS_SEG_HI)
				eth_segment[15:8] = b;
		end
		if (rel == rec_len - 1) begin
			if (eth_pending) begin
				scan_state = ST_FOUND;
			end else begin
				nxt = rec_start + rec_len;
				if (nxt >= OFF_LIMIT)
					scan_state = ST_STOPPED;
				else
					rec_start = nxt[15:0];
			end
		end
	endfunction

	function automatic void predict_beat(input logic [7:0] b, input logic last);
		scan_result_t r;
		bit hit;
		scan_descriptor_byte(b);
		if (last) begin
			hit = scan_state == ST_FOUND && scan_offset >= MIN_BLOCK_LEN;
			r.found     = hit;
			r.mac_index = hit ? eth_index : 8'h00;
			r.segment   = (hit && eth_segment != 0) ? eth_segment : default_seg;
			expected_reports.push_back(r);
			restart_scan();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int  gap;
		bit  stalled;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		config_byte <= b;
		last_byte   <= last;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict_beat(b, last);
	endtask

	task automatic send_block();
		if (blk.size() == 0)
			blk.push_back(8'($urandom_range(0, 255)));
		foreach (blk[i])
			send_byte(blk[i], i == blk.size() - 1);
		blk.delete();
	endtask

	// hold the sender until every report is back, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_reports.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_default_segment(input logic [SEG_W-1:0] v);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({REG_DEFAULT_SEGMENT, 2'b00});
		pwdata  <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		default_seg = v;
	endtask

	function automatic void add_bytes(input int n);
		repeat (n) blk.push_back(8'($urandom_range(0, 255)));
	endfunction

	// header whose length byte is n, padded out with random bytes
	function automatic void add_header(input logic [7:0] n);
		blk.push_back(n);
		if (n > 1)
			add_bytes(n - 1);
	endfunction

	function automatic void add_record(input logic [7:0] len, input logic [7:0] kind,
			input logic [7:0] sub, input logic [7:0] idx, input logic [SEG_W-1:0] seg);
		int n;
		n = (len == 0) ? 1 : len;
		for (int i = 0; i < n; i++) begin
			case (i)
				0: blk.push_back(len);
				1: blk.push_back(kind);
				2: blk.push_back(sub);
				3: blk.push_back(idx);
				8: blk.push_back(seg[7:0]);
				9: blk.push_back(seg[15:8]);
				default: blk.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	function automatic void add_eth(input logic [7:0] idx, input logic [SEG_W-1:0] seg,
			input logic [7:0] len);
		add_record(len, KIND_CS_INTERFACE, SUBTYPE_ETHERNET, idx, seg);
	endfunction

	function automatic void add_other(input logic [7:0] len);
		add_record(len, 8'h04, 8'h00, 8'h00, 16'h0000);
	endfunction

	// receiver: stall on a pattern that changes mode every so often
	int rx_mode = 0;
	int rx_left = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((rx_left % 11) < 4);
		endcase
	end

	// outputs are settled by the falling edge; the beat is taken at the next rise
	always @(negedge clk) begin
		scan_result_t got;
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {found, mac_string_index, segment_size};
			if (expected_reports.size() == 0) begin
				bad_reports++;
				if (bad_reports <= 10)
					$display("%0t: unexpected report found=%b index=%02h segment=%04h",
						$realtime, got.found, got.mac_index, got.segment);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					bad_reports++;
					if (bad_reports <= 10)
						$display({"%0t: expected found=%b index=%02h segment=%04h, ",
							"got found=%b index=%02h segment=%04h"},
							$realtime, want.found, want.mac_index, want.segment,
							got.found, got.mac_index, got.segment);
				end
			end
		end
	end

	task automatic test_reset_default();
		add_header(9);
		add_other(5);
		send_block();
		blk.push_back(8'hFF);
		send_block();
		drain();
	endtask

	task automatic test_match();
		add_header(9);
		add_eth(8'hA5, 16'h05EA, 13);
		send_block();
		add_header(9);
		add_other(5);
		add_eth(8'h00, 16'hFFFF, 255);
		send_block();
		// zero segment falls back to the register
		add_header(9);
		add_eth(8'hFF, 16'h0000, 13);
		send_block();
		blk.push_back(8'h01);
		add_eth(8'h3C, 16'h8001, 13);
		send_block();
		add_header(255);
		add_eth(8'h5A, 16'h7FFE, 14);
		send_block();
		drain();
	endtask

	task automatic test_special_cases();
		// short blocks
		add_bytes(8);
		send_block();
		add_bytes(9);
		send_block();
		// zero header length
		blk.push_back(8'h00);
		add_eth(8'h11, 16'h1111, 13);
		send_block();
		// record lengths below two
		add_header(9);
		add_record(1, 8'h24, 8'h0F, 8'h22, 16'h2222);
		add_eth(8'h22, 16'h2222, 13);
		send_block();
		add_header(9);
		add_record(0, 8'h24, 8'h0F, 8'h33, 16'h3333);
		add_eth(8'h33, 16'h3333, 13);
		send_block();
		// truncated match, then a lone trailing byte
		add_header(9);
		add_eth(8'h44, 16'h4444, 13);
		void'(blk.pop_back());
		void'(blk.pop_back());
		void'(blk.pop_back());
		send_block();
		add_header(9);
		add_other(4);
		add_bytes(1);
		send_block();
		// first match cut short hides a complete one inside it
		add_header(9);
		add_eth(8'h55, 16'h5555, 30);
		while (blk.size() > 9 + 13)
			void'(blk.pop_back());
		add_eth(8'h66, 16'h6666, 13);
		send_block();
		// bytes after a match are ignored
		add_header(9);
		add_eth(8'h77, 16'h0777, 13);
		add_eth(8'h88, 16'h0888, 13);
		add_bytes(5);
		send_block();
		// near misses ahead of the real one
		add_header(9);
		add_record(12, KIND_CS_INTERFACE, SUBTYPE_ETHERNET, 8'h01, 16'h0101);
		add_record(13, KIND_CS_INTERFACE, 8'h0E, 8'h02, 16'h0202);
		add_record(13, 8'h25, SUBTYPE_ETHERNET, 8'h03, 16'h0303);
		add_eth(8'h99, 16'h0999, 16);
		send_block();
		drain();
	endtask

	task automatic test_default_register();
		logic [SEG_W-1:0] values[3];
		values = '{16'h0000, 16'hFFFF, SEG_W'($urandom_range(1, 65534))};
		foreach (values[i]) begin
			write_default_segment(values[i]);
			add_header(9);
			add_other(6);
			send_block();
			add_header(9);
			add_eth(8'($urandom_range(0, 255)), 16'h0000, 13);
			send_block();
			add_header(9);
			add_eth(8'($urandom_range(0, 255)), 16'h1234, 13);
			send_block();
			drain();
		end
	endtask

	task automatic add_random_record();
		int pick;
		logic [SEG_W-1:0] seg;
		logic [7:0] sub;
		pick = $urandom_range(0, 99);
		seg = ($urandom_range(0, 5) == 0) ? 16'h0000 : SEG_W'($urandom_range(0, 65535));
		if (pick < 40) begin
			add_eth(8'($urandom_range(0, 255)), seg, 8'($urandom_range(13, 24)));
		end else if (pick < 48) begin
			add_record(8'($urandom_range(2, 12)), KIND_CS_INTERFACE, SUBTYPE_ETHERNET,
				8'($urandom_range(0, 255)), seg);
		end else if (pick < 55) begin
			sub = 8'($urandom_range(0, 255));
			if (sub == SUBTYPE_ETHERNET)
				sub = sub ^ 8'h01;
			add_record(8'($urandom_range(13, 20)), KIND_CS_INTERFACE, sub,
				8'($urandom_range(0, 255)), seg);
		end else if (pick < 97) begin
			add_record(8'($urandom_range(2, 16)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), seg);
		end else begin
			add_record(8'($urandom_range(0, 1)), KIND_CS_INTERFACE, SUBTYPE_ETHERNET,
				8'($urandom_range(0, 255)), seg);
		end
	endtask

	task automatic test_random_blocks();
		int pick;
		int next_cfg;
		next_cfg = 200;
		while (random_sent < RANDOM_BYTES) begin
			if (random_sent >= next_cfg) begin
				drain();
				pick = $urandom_range(0, 3);
				write_default_segment(pick == 0 ? 16'h0000 :
					pick == 1 ? 16'hFFFF : SEG_W'($urandom_range(0, 65535)));
				next_cfg += 200;
			end
			if ($urandom_range(0, 3) == 0) begin
				add_bytes($urandom_range(1, 40));
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					blk.push_back(8'h00);
				else if (pick < 14)
					add_header(9);
				else
					add_header(8'($urandom_range(1, 40)));
				repeat ($urandom_range(0, 4)) add_random_record();
				pick = $urandom_range(0, 9);
				if (pick == 0 && blk.size() > 1)
					repeat ($urandom_range(1, (blk.size() > 6) ? 5 : blk.size() - 1))
						void'(blk.pop_back());
				else if (pick == 1)
					add_bytes(1);
			end
			random_sent += blk.size();
			send_block();
		end
		drain();
	endtask

	initial begin
		restart_scan();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_default();
		test_match();
		test_special_cases();
		test_default_register();
		test_random_blocks();
		repeat (8) @(posedge clk);
		if (bad_reports == 0 && expected_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#50000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: cdc_ethernet_descriptor_finder.f
+incdir+hdl
hdl/cdf_pkg.sv
hdl/cdf_apb_regs.sv
hdl/cdf_scan_core.sv
hdl/cdc_ethernet_descriptor_finder.sv
hdl/cdf_checker.sv
sim/testbench.sv
